### src/pfi_pkg.sv
`default_nettype none

package pfi_pkg;

	localparam int DEF_CHANNELS = 768;

	localparam int CH_W  = 10;
	localparam int LVL_W = 8;
	localparam int DUR_W = 16;
	localparam int ACC_W = 16;

	localparam logic OP_SETUP = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_UPD,
		ST_DIV,
		ST_RESP
	} state_t;

	// one stored channel: 8.8 accumulator and signed 8.8 step
	typedef struct packed {
		logic [ACC_W-1:0] acc;
		logic [ACC_W-1:0] step;
	} entry_t;

	typedef struct packed {
		logic   we;
		entry_t data;
	} mem_wr_t;

endpackage

`default_nettype wire

### src/pfi_divider.sv
`default_nettype none

// Restoring radix-2 divider, one quotient bit per cycle.
module pfi_divider (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic [pfi_pkg::ACC_W-1:0] dividend,
	input  wire logic [pfi_pkg::ACC_W-1:0] divisor,
	output logic                         done,
	output logic [pfi_pkg::ACC_W-1:0]    quotient
);

	localparam int DW    = pfi_pkg::ACC_W;
	localparam int CNT_W = $clog2(DW);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    dvd_q;
	logic [DW-1:0]    dsr_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    quo_q;

	logic [DW:0] rem_sh;
	logic        ge;
	logic [DW:0] rem_nx;

	always_comb begin
		rem_sh = {rem_q, dvd_q[DW-1]};
		ge     = rem_sh >= {1'b0, dsr_q};
		rem_nx = ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DW-2:0], 1'b0};
			rem_q <= rem_nx[DW-1:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider restarted while busy");

	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && $past(busy_q)) else $error("done without a finished run");

endmodule

`default_nettype wire

### src/pfi_state_mem.sv
`default_nettype none

// Per-channel accumulator and step store, one write and one registered read port.
module pfi_state_mem #(
	parameter int CHANNELS = pfi_pkg::DEF_CHANNELS,
	parameter int AW       = $clog2(CHANNELS)
) (
	input  wire logic             clk,
	input  wire pfi_pkg::mem_wr_t wr,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [AW-1:0]    raddr,
	output pfi_pkg::entry_t       rdata
);

	pfi_pkg::entry_t mem_q [CHANNELS];
	pfi_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem_q[waddr] <= wr.data;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### src/palette_fade_interpolator.sv
`default_nettype none

// Palette fade interpolator: keeps an 8.8 accumulator and step per colour channel.
// An item is taken when start is high and busy is low; busy then stays high until
// the result has been shown. Each item gives one result, presented on channel_echo
// and level for exactly one cycle with done high; the receiver cannot stall it and
// must take it in that cycle. A step item passes through the memory read, add and
// write-back, and result states. A setup item waits on the shared restoring divider
// that produces one quotient bit per cycle for the 16-bit step. An item naming a
// channel at or above CHANNELS leaves state alone and goes straight to the result
// with level 0. Stepping a channel never set up gives an undefined level. The store
// needs no clearing after reset.
module palette_fade_interpolator #(
	parameter int CHANNELS = pfi_pkg::DEF_CHANNELS
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic                        opcode,
	input  wire logic [pfi_pkg::CH_W-1:0]    channel_index,
	input  wire logic [pfi_pkg::LVL_W-1:0]   current_level,
	input  wire logic [pfi_pkg::LVL_W-1:0]   target_level,
	input  wire logic [pfi_pkg::DUR_W-1:0]   duration,
	output logic                             done,
	output logic [pfi_pkg::CH_W-1:0]         channel_echo,
	output logic [pfi_pkg::LVL_W-1:0]        level
);

	localparam int AW    = $clog2(CHANNELS);
	localparam int ACC_W = pfi_pkg::ACC_W;
	localparam int LVL_W = pfi_pkg::LVL_W;

	pfi_pkg::state_t state_q, state_d;

	logic                      op_q;
	logic [pfi_pkg::CH_W-1:0]  ch_q;
	logic [LVL_W-1:0]          cur_q;
	logic [LVL_W-1:0]          tgt_q;
	logic [LVL_W-1:0]          level_q;

	logic accept;
	logic in_range;

	logic [LVL_W-1:0] diff;
	logic [ACC_W-1:0] div_dividend;
	logic [ACC_W-1:0] div_divisor;
	logic             div_start;
	logic             div_done;
	logic [ACC_W-1:0] div_quo;

	pfi_pkg::mem_wr_t mem_wr;
	pfi_pkg::entry_t  mem_rd;
	logic [ACC_W-1:0] sum;

	assign accept   = start && !busy;
	assign in_range = 32'(channel_index) < 32'(CHANNELS);

	// dividend is (|target - current| << 8) + 1; zero duration divides by one
	always_comb begin
		diff         = (target_level > current_level) ? (target_level - current_level)
		                                              : (current_level - target_level);
		div_dividend = {diff, 8'h01};
		div_divisor  = (duration == '0) ? ACC_W'(1) : duration;
		div_start    = accept && in_range && (opcode == pfi_pkg::OP_SETUP);
	end

	pfi_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	pfi_state_mem #(
		.CHANNELS (CHANNELS),
		.AW       (AW)
	) u_mem (
		.clk   (clk),
		.wr    (mem_wr),
		.waddr (AW'(ch_q)),
		.raddr (AW'(ch_q)),
		.rdata (mem_rd)
	);

	assign sum = mem_rd.acc + mem_rd.step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfi_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		mem_wr.we    = 1'b0;
		mem_wr.data  = '{acc: sum, step: mem_rd.step};
		unique case (state_q)
			pfi_pkg::ST_IDLE: begin
				if (accept) begin
					if (!in_range) begin
						state_d = pfi_pkg::ST_RESP;
					end else if (opcode == pfi_pkg::OP_STEP) begin
						state_d = pfi_pkg::ST_RD;
					end else begin
						state_d = pfi_pkg::ST_DIV;
					end
				end
			end
			pfi_pkg::ST_RD: begin
				state_d = pfi_pkg::ST_UPD;
			end
			pfi_pkg::ST_UPD: begin
				mem_wr.we = 1'b1;
				state_d   = pfi_pkg::ST_RESP;
			end
			pfi_pkg::ST_DIV: begin
				// negate the step when fading down or holding level
				mem_wr.data.acc  = {cur_q, 8'h00};
				mem_wr.data.step = (tgt_q <= cur_q) ? (~div_quo + ACC_W'(1)) : div_quo;
				if (div_done) begin
					mem_wr.we = 1'b1;
					state_d   = pfi_pkg::ST_RESP;
				end
			end
			pfi_pkg::ST_RESP: begin
				state_d = pfi_pkg::ST_IDLE;
			end
			default: begin
				state_d = pfi_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= opcode;
			ch_q  <= channel_index;
			cur_q <= current_level;
			tgt_q <= target_level;
			if (!in_range) begin
				level_q <= '0;
			end
		end else if (state_q == pfi_pkg::ST_UPD) begin
			level_q <= sum[ACC_W-1 -: LVL_W];
		end else if (state_q == pfi_pkg::ST_DIV && div_done) begin
			level_q <= cur_q;
		end
	end

	assign busy         = (state_q != pfi_pkg::ST_IDLE);
	assign done         = (state_q == pfi_pkg::ST_RESP);
	assign channel_echo = ch_q;
	assign level        = level_q;

	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("result held longer than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy) else $error("item accepted but block not busy");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == pfi_pkg::ST_DIV) else $error("divider result unclaimed");

	a_step_path: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pfi_pkg::ST_UPD |-> op_q == pfi_pkg::OP_STEP && $past(state_q) == pfi_pkg::ST_RD)
		else $error("update without a step read");

	a_setup_level: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pfi_pkg::ST_DIV && div_done |=> done && level == $past(cur_q))
		else $error("setup result does not show current level");

endmodule

`default_nettype wire
